// ===== rtl/tsa_pkg.sv =====
`default_nettype none
package tsa_pkg;

  localparam int SLOT_COUNT   = 10;
  localparam int STAMP_BITS   = 32;
  localparam int CFG_BITS     = 32;
  localparam int FRAME_BITS   = 32;
  localparam int IDX_BITS     = $clog2(SLOT_COUNT);
  localparam int OUT_IDX_BITS = 4;
  localparam int CMP_BITS     = (STAMP_BITS > CFG_BITS) ? STAMP_BITS : CFG_BITS;
  localparam int LFSR_BITS    = 16;
  localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'hACE1;
  localparam int CFG_RESET    = 480;

  localparam logic CMD_AGE   = 1'b0;
  localparam logic CMD_CLAIM = 1'b1;

  // search word handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  cmd;
    logic [STAMP_BITS-1:0] now;
    logic [CFG_BITS-1:0]   half;
    logic                  free_found;
    logic [IDX_BITS-1:0]   free_idx;
    logic [STAMP_BITS-1:0] min_stamp;
    logic [IDX_BITS-1:0]   min_idx;
    logic                  same;
    logic [STAMP_BITS-1:0] first_stamp;
  } scan_t;

  // slot update broadcast at the end of a claim
  typedef struct packed {
    logic                  en;
    logic [IDX_BITS-1:0]   idx;
    logic [STAMP_BITS-1:0] stamp;
  } wr_t;

  function automatic logic [LFSR_BITS-1:0] lfsr_next(input logic [LFSR_BITS-1:0] s);
    logic b;
    b = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {b, s[LFSR_BITS-1:1]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tsa_cell.sv =====
`default_nettype none
module tsa_cell (
  input  wire                           clk,
  input  wire                           rst,
  input  wire  [tsa_pkg::IDX_BITS-1:0]  index,
  input  tsa_pkg::scan_t                scan_in,
  input  tsa_pkg::wr_t                  wr,
  output tsa_pkg::scan_t                scan_out
);
  import tsa_pkg::*;

  logic                  busy;
  logic [STAMP_BITS-1:0] stamp;

  logic                  head;
  logic [STAMP_BITS-1:0] age;
  logic                  expire;
  scan_t                 scan_next;

  assign head   = (index == '0);
  assign age    = scan_in.now - stamp;
  assign expire = scan_in.valid && (scan_in.cmd == CMD_AGE) && (stamp != '0) &&
                  (CMP_BITS'(age) > CMP_BITS'(scan_in.half));

  always_comb begin
    scan_next = scan_in;
    if (scan_in.cmd == CMD_CLAIM) begin
      if (head) begin
        scan_next.first_stamp = stamp;
        scan_next.same        = 1'b1;
      end else if (stamp != scan_in.first_stamp) begin
        scan_next.same = 1'b0;
      end
      if (stamp < scan_in.min_stamp) begin
        scan_next.min_stamp = stamp;
        scan_next.min_idx   = index;
      end
      if (!scan_in.free_found && !busy) begin
        scan_next.free_found = 1'b1;
        scan_next.free_idx   = index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      stamp <= '0;
    end else if (expire) begin
      busy  <= 1'b0;
      stamp <= '0;
    end else if (wr.en && (wr.idx == index)) begin
      busy  <= 1'b1;
      stamp <= wr.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out <= scan_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/timed_slot_allocator_oldest_replace.sv =====
// Flow: the search word passes the head register and then the register of each slot cell; an
//   age-out word is done when it leaves the tail, and a claim then goes through ST_DONE, with
//   ST_MOD first when no slot is free and all stamps are equal (LFSR modulo), to load its result.
// Throughput: one word at a time; the next word is taken only once the state is back in ST_IDLE,
//   and ST_DONE holds a claim while the result register is not free.
// Reset (synchronous, active high): all slots free, stamps zero, LFSR 0xACE1, erase_count 480.
`default_nettype none
module timed_slot_allocator_oldest_replace (
  input  wire         clk,
  input  wire         rst,
  // configuration: erase_count
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata,
  // input stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // [31:0] frame_now
  input  wire  [0:0]  s_tuser,   // [0] cmd
  // result stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // [3:0] slot_index, [7:4] zero
  output logic [0:0]  m_tuser    // [0] replaced
);
  import tsa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // reciprocal of the slot count, exact for every LFSR value
  localparam int RECIP_SHIFT = LFSR_BITS + IDX_BITS;
  localparam int RECIP_BITS  = LFSR_BITS + 1;
  localparam int PROD_BITS   = LFSR_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'((2 ** RECIP_SHIFT + SLOT_COUNT - 1) / SLOT_COUNT);

  logic [1:0]            state;
  logic [CFG_BITS-1:0]   erase_count;
  logic [LFSR_BITS-1:0]  lfsr;
  logic [STAMP_BITS-1:0] cur_now;
  logic [IDX_BITS-1:0]   res_idx;
  logic                  res_replaced;
  logic [LFSR_BITS-1:0]  rem;

  scan_t scan_head;
  scan_t chain [SLOT_COUNT+1];
  scan_t tail;
  wr_t   wr;

  logic                  accept;
  logic                  out_free;
  logic [PROD_BITS-1:0]  quo_prod;
  logic [LFSR_BITS-1:0]  quo;
  logic [LFSR_BITS-1:0]  rem_mod;
  logic [LFSR_BITS-1:0]  lfsr_adv;
  logic [IDX_BITS+OUT_IDX_BITS-1:0] idx_wide;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign tail     = chain[SLOT_COUNT];
  assign lfsr_adv = lfsr_next(lfsr);

  // reduce the advanced LFSR modulo the slot count by reciprocal multiplication
  assign quo_prod = PROD_BITS'(rem) * PROD_BITS'(RECIP);
  assign quo      = LFSR_BITS'(quo_prod >> RECIP_SHIFT);
  assign rem_mod  = rem - LFSR_BITS'(quo * LFSR_BITS'(SLOT_COUNT));

  // commit the granted slot as the result word is loaded
  assign wr.en    = (state == ST_DONE) && out_free;
  assign wr.idx   = res_idx;
  assign wr.stamp = cur_now;

  assign idx_wide = {{OUT_IDX_BITS{1'b0}}, res_idx};

  // row of slot cells; the search word enters at the head and leaves at the tail
  assign chain[0] = scan_head;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
    tsa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .index    (IDX_BITS'(i)),
      .scan_in  (chain[i]),
      .wr       (wr),
      .scan_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      erase_count <= CFG_BITS'(CFG_RESET);
    end else if (cfg_we) begin
      erase_count <= cfg_wdata;
    end
  end

  // inject the search word for one cycle on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_head.valid <= 1'b0;
    end else begin
      scan_head.valid       <= accept;
      scan_head.cmd         <= s_tuser[0];
      scan_head.now         <= STAMP_BITS'(s_tdata);
      scan_head.half        <= erase_count >> 1;
      scan_head.free_found  <= 1'b0;
      scan_head.free_idx    <= '0;
      scan_head.min_stamp   <= '1;
      scan_head.min_idx     <= '0;
      scan_head.same        <= 1'b1;
      scan_head.first_stamp <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_now <= STAMP_BITS'(s_tdata);
    end
  end

  // raise the result word when loaded, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      lfsr     <= LFSR_SEED;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tail.valid) begin
            priority if (tail.cmd == CMD_AGE) begin
              state <= ST_IDLE;
            end else if (tail.free_found) begin
              res_idx      <= tail.free_idx;
              res_replaced <= 1'b0;
              state        <= ST_DONE;
            end else if (tail.same) begin
              // all stamps equal: advance the LFSR and reduce it modulo the slot count
              lfsr         <= lfsr_adv;
              rem          <= lfsr_adv;
              res_replaced <= 1'b1;
              state        <= ST_MOD;
            end else begin
              res_idx      <= tail.min_idx;
              res_replaced <= 1'b1;
              state        <= ST_DONE;
            end
          end
        end
        ST_MOD: begin
          res_idx <= rem_mod[IDX_BITS-1:0];
          state   <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the result register is free
          if (out_free) begin
            m_tdata  <= 8'(idx_wide[OUT_IDX_BITS-1:0]);
            m_tuser  <= res_replaced;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
